>>> rtl/plc_pkg.sv
// Package for the polyline length clipper: payload structs, widths and state codes.
// Depends on nothing; used by rtl/polyline_length_clip.sv.
`default_nettype none
package plc_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LEN_BITS   = 31;
  localparam int WALK_BITS  = 40;

  // Derived widths of the serial datapath.
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int RAD_BITS   = 2 * MAG_BITS;
  localparam int ACC_BITS   = MAG_BITS + 3;
  localparam int PROD_BITS  = MAG_BITS + LEN_BITS;
  localparam int CNT_BITS   = 7;

  // Smallest remainder of the cap that still allows a cut inside a leg.
  localparam int CUT_MIN    = (1 << FRAC_BITS) / 100 + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic signed [COORD_BITS-1:0] pt_z;
    logic                         route_end;
  } in_pt_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         out_last;
    logic                         was_clipped;
  } out_pt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_SQRT,
    S_CMP,
    S_EMIT_HELD,
    S_EMIT_PT,
    S_LINIT,
    S_LMUL,
    S_LDIV,
    S_LFIN,
    S_EMIT_CUT
  } state_t;

  typedef enum logic [1:0] {
    PLAN_PASS,
    PLAN_NEAR,
    PLAN_CUT
  } plan_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

endpackage
`default_nettype wire

>>> rtl/polyline_length_clip.sv
// Top level of the polyline length clipper: bit-serial leg length and cut point unit.
// Depends on plc_pkg for payload structs, widths and state codes.
`default_nettype none
// The block takes route points one transaction at a time and holds one point back so the
// final emitted point can carry out_last. The first point of a route, and points dropped
// after a cut, need no leg computation. Every further point runs a shift-add multiplier
// that forms dx*dx + dy*dy one multiplier bit per cycle, then a restoring square root
// that produces the leg length one root bit per cycle. A leg that is cut then runs, for
// each of the three coordinates, a shift-add product with the remaining length and a
// restoring divide by the leg. An output register decouples the result side, so a new
// point is taken while the last result of a route still waits. The cap register may be
// written at any time the block is idle.
module polyline_length_clip (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire plc_pkg::in_pt_t               in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output plc_pkg::out_pt_t                   out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [plc_pkg::LEN_BITS-1:0]  cfg_data
);

  localparam int CW  = plc_pkg::COORD_BITS;
  localparam int MW  = plc_pkg::MAG_BITS;
  localparam int RW  = plc_pkg::RAD_BITS;
  localparam int AW  = plc_pkg::ACC_BITS;
  localparam int LW  = plc_pkg::LEN_BITS;
  localparam int WW  = plc_pkg::WALK_BITS;
  localparam int PW  = plc_pkg::PROD_BITS;
  localparam int NW  = plc_pkg::CNT_BITS;

  plc_pkg::state_t state_r, state_nxt;
  plc_pkg::plan_t  plan_r, plan_nxt;
  plc_pkg::axis_t  axis_r, axis_nxt;

  logic [LW-1:0]  max_len_r, max_len_nxt;
  logic           have_held_r, have_held_nxt;
  logic           discarding_r, discarding_nxt;
  logic [WW-1:0]  walk_r, walk_nxt;
  logic [CW-1:0]  held_x_r, held_x_nxt, held_y_r, held_y_nxt, held_z_r, held_z_nxt;
  plc_pkg::in_pt_t pt_r, pt_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;

  // Leg length datapath.
  logic [MW-1:0]  ax_r, ax_nxt, ay_r, ay_nxt, mx_r, mx_nxt, my_r, my_nxt;
  logic [AW-1:0]  hi_r, hi_nxt;
  logic [MW-1:0]  lo_r, lo_nxt;
  logic [RW-1:0]  rad_r, rad_nxt;
  logic [AW-1:0]  srem_r, srem_nxt;
  logic [MW-1:0]  leg_r, leg_nxt;

  // Cut point datapath.
  logic [LW-1:0]  rem_r, rem_nxt;
  logic [MW-1:0]  dmag_r, dmag_nxt;
  logic           dneg_r, dneg_nxt;
  logic [LW-1:0]  lm_r, lm_nxt;
  logic [MW-1:0]  lhi_r, lhi_nxt;
  logic [LW-1:0]  llo_r, llo_nxt;
  logic [PW-1:0]  num_r, num_nxt;
  logic [MW-1:0]  drem_r, drem_nxt;
  logic [MW-1:0]  quo_r, quo_nxt;
  logic [CW-1:0]  cut_x_r, cut_x_nxt, cut_y_r, cut_y_nxt, cut_z_r, cut_z_nxt;

  logic             out_valid_r, out_valid_nxt;
  plc_pkg::out_pt_t out_data_r, out_data_nxt;

  // Combinational helpers.
  logic           in_acc, slot_free;
  logic [MW-1:0]  dx, dy, dsel, dmag_c;
  logic [CW-1:0]  hsel, psel;
  logic [AW-1:0]  msum, sq_sh, sq_try;
  logic [MW:0]    lsum;
  logic [MW:0]    dv_sh;
  logic [WW:0]    wsum;
  logic           pass, near;
  logic [LW-1:0]  rem_c;
  logic [MW:0]    h_ext, lerp_v;

  function automatic logic [MW-1:0] mag_of(input logic [MW-1:0] d);
    mag_of = d[MW-1] ? (~d + MW'(1)) : d;
  endfunction

  assign in_ready  = (state_r == plc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    dx = {pt_r.pt_x[CW-1], pt_r.pt_x} - {held_x_r[CW-1], held_x_r};
    dy = {pt_r.pt_y[CW-1], pt_r.pt_y} - {held_y_r[CW-1], held_y_r};
    case (axis_r)
      plc_pkg::AX_X: begin
        hsel = held_x_r;
        psel = pt_r.pt_x;
      end
      plc_pkg::AX_Y: begin
        hsel = held_y_r;
        psel = pt_r.pt_y;
      end
      default: begin
        hsel = held_z_r;
        psel = pt_r.pt_z;
      end
    endcase
    dsel   = {psel[CW-1], psel} - {hsel[CW-1], hsel};
    dmag_c = mag_of(dsel);
    msum   = hi_r + (mx_r[0] ? AW'(ax_r) : '0) + (my_r[0] ? AW'(ay_r) : '0);
    sq_sh  = {srem_r[AW-3:0], rad_r[RW-1 -: 2]};
    sq_try = AW'({leg_r, 2'b01});
    lsum   = {1'b0, lhi_r} + (lm_r[0] ? {1'b0, dmag_r} : '0);
    dv_sh  = {drem_r, num_r[PW-1]};
    wsum   = {1'b0, walk_r} + (WW + 1)'(leg_r);
    pass   = (max_len_r == '0) || (wsum <= (WW + 1)'(max_len_r));
    rem_c  = max_len_r - walk_r[LW-1:0];
    near   = (walk_r >= WW'(max_len_r)) || (rem_c < LW'(plc_pkg::CUT_MIN));
    h_ext  = {{2{hsel[CW-1]}}, hsel};
    lerp_v = dneg_r ? (h_ext - {1'b0, quo_r}) : (h_ext + {1'b0, quo_r});
  end

  always_comb begin
    state_nxt      = state_r;
    plan_nxt       = plan_r;
    axis_nxt       = axis_r;
    max_len_nxt    = cfg_valid ? cfg_data : max_len_r;
    have_held_nxt  = have_held_r;
    discarding_nxt = discarding_r;
    walk_nxt       = walk_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    held_z_nxt     = held_z_r;
    pt_nxt         = pt_r;
    cnt_nxt        = cnt_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    mx_nxt         = mx_r;
    my_nxt         = my_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    rad_nxt        = rad_r;
    srem_nxt       = srem_r;
    leg_nxt        = leg_r;
    rem_nxt        = rem_r;
    dmag_nxt       = dmag_r;
    dneg_nxt       = dneg_r;
    lm_nxt         = lm_r;
    lhi_nxt        = lhi_r;
    llo_nxt        = llo_r;
    num_nxt        = num_r;
    drem_nxt       = drem_r;
    quo_nxt        = quo_r;
    cut_x_nxt      = cut_x_r;
    cut_y_nxt      = cut_y_r;
    cut_z_nxt      = cut_z_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      plc_pkg::S_IDLE: begin
        if (in_acc) begin
          pt_nxt = in_data;
          if (discarding_r) begin
            if (in_data.route_end) begin
              discarding_nxt = 1'b0;
            end
          end else if (!have_held_r) begin
            if (in_data.route_end) begin
              state_nxt = plc_pkg::S_EMIT_PT;
            end else begin
              held_x_nxt    = in_data.pt_x;
              held_y_nxt    = in_data.pt_y;
              held_z_nxt    = in_data.pt_z;
              have_held_nxt = 1'b1;
            end
          end else begin
            state_nxt = plc_pkg::S_DIFF;
          end
        end
      end
      plc_pkg::S_DIFF: begin
        ax_nxt    = mag_of(dx);
        ay_nxt    = mag_of(dy);
        mx_nxt    = mag_of(dx);
        my_nxt    = mag_of(dy);
        hi_nxt    = '0;
        lo_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = plc_pkg::S_MUL;
      end
      plc_pkg::S_MUL: begin
        // One bit of each multiplier per cycle; the sum of both squares builds up.
        hi_nxt  = msum >> 1;
        lo_nxt  = {msum[0], lo_r[MW-1:1]};
        mx_nxt  = mx_r >> 1;
        my_nxt  = my_r >> 1;
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(MW - 1)) begin
          state_nxt = plc_pkg::S_SQRT;
          cnt_nxt   = '0;
          srem_nxt  = '0;
          leg_nxt   = '0;
          rad_nxt   = {msum[MW:1], msum[0], lo_r[MW-1:1]};
        end
      end
      plc_pkg::S_SQRT: begin
        // Restoring square root, one root bit per cycle from the top.
        rad_nxt = rad_r << 2;
        if (sq_sh >= sq_try) begin
          srem_nxt = sq_sh - sq_try;
          leg_nxt  = {leg_r[MW-2:0], 1'b1};
        end else begin
          srem_nxt = sq_sh;
          leg_nxt  = {leg_r[MW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(MW - 1)) begin
          state_nxt = plc_pkg::S_CMP;
        end
      end
      plc_pkg::S_CMP: begin
        rem_nxt   = rem_c;
        state_nxt = plc_pkg::S_EMIT_HELD;
        if (pass) begin
          plan_nxt = plc_pkg::PLAN_PASS;
          walk_nxt = wsum[WW] ? '1 : wsum[WW-1:0];
        end else if (near) begin
          plan_nxt = plc_pkg::PLAN_NEAR;
        end else begin
          plan_nxt = plc_pkg::PLAN_CUT;
        end
      end
      plc_pkg::S_EMIT_HELD: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_x       = held_x_r;
          out_data_nxt.out_y       = held_y_r;
          out_data_nxt.out_z       = held_z_r;
          out_data_nxt.out_last    = (plan_r == plc_pkg::PLAN_NEAR);
          out_data_nxt.was_clipped = (plan_r == plc_pkg::PLAN_NEAR);
          case (plan_r)
            plc_pkg::PLAN_PASS: begin
              if (pt_r.route_end) begin
                state_nxt = plc_pkg::S_EMIT_PT;
              end else begin
                held_x_nxt = pt_r.pt_x;
                held_y_nxt = pt_r.pt_y;
                held_z_nxt = pt_r.pt_z;
                state_nxt  = plc_pkg::S_IDLE;
              end
            end
            plc_pkg::PLAN_NEAR: begin
              have_held_nxt  = 1'b0;
              walk_nxt       = '0;
              discarding_nxt = !pt_r.route_end;
              state_nxt      = plc_pkg::S_IDLE;
            end
            default: begin
              axis_nxt  = plc_pkg::AX_X;
              state_nxt = plc_pkg::S_LINIT;
            end
          endcase
        end
      end
      plc_pkg::S_EMIT_PT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_x       = pt_r.pt_x;
          out_data_nxt.out_y       = pt_r.pt_y;
          out_data_nxt.out_z       = pt_r.pt_z;
          out_data_nxt.out_last    = 1'b1;
          out_data_nxt.was_clipped = 1'b0;
          have_held_nxt            = 1'b0;
          walk_nxt                 = '0;
          state_nxt                = plc_pkg::S_IDLE;
        end
      end
      plc_pkg::S_LINIT: begin
        dmag_nxt  = dmag_c;
        dneg_nxt  = dsel[MW-1];
        lm_nxt    = rem_r;
        lhi_nxt   = '0;
        llo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = plc_pkg::S_LMUL;
      end
      plc_pkg::S_LMUL: begin
        lhi_nxt = lsum[MW:1];
        llo_nxt = {lsum[0], llo_r[LW-1:1]};
        lm_nxt  = lm_r >> 1;
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(LW - 1)) begin
          num_nxt   = {lsum[MW:1], lsum[0], llo_r[LW-1:1]};
          drem_nxt  = '0;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = plc_pkg::S_LDIV;
        end
      end
      plc_pkg::S_LDIV: begin
        // Restoring divide by the leg length, one quotient bit per cycle.
        num_nxt = num_r << 1;
        if (dv_sh >= {1'b0, leg_r}) begin
          drem_nxt = MW'(dv_sh - {1'b0, leg_r});
          quo_nxt  = {quo_r[MW-2:0], 1'b1};
        end else begin
          drem_nxt = dv_sh[MW-1:0];
          quo_nxt  = {quo_r[MW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(PW - 1)) begin
          state_nxt = plc_pkg::S_LFIN;
        end
      end
      plc_pkg::S_LFIN: begin
        case (axis_r)
          plc_pkg::AX_X: begin
            cut_x_nxt = lerp_v[CW-1:0];
            axis_nxt  = plc_pkg::AX_Y;
            state_nxt = plc_pkg::S_LINIT;
          end
          plc_pkg::AX_Y: begin
            cut_y_nxt = lerp_v[CW-1:0];
            axis_nxt  = plc_pkg::AX_Z;
            state_nxt = plc_pkg::S_LINIT;
          end
          default: begin
            cut_z_nxt = lerp_v[CW-1:0];
            state_nxt = plc_pkg::S_EMIT_CUT;
          end
        endcase
      end
      plc_pkg::S_EMIT_CUT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_x       = cut_x_r;
          out_data_nxt.out_y       = cut_y_r;
          out_data_nxt.out_z       = cut_z_r;
          out_data_nxt.out_last    = 1'b1;
          out_data_nxt.was_clipped = 1'b1;
          have_held_nxt            = 1'b0;
          walk_nxt                 = '0;
          discarding_nxt           = !pt_r.route_end;
          state_nxt                = plc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= plc_pkg::S_IDLE;
      plan_r       <= plc_pkg::PLAN_PASS;
      axis_r       <= plc_pkg::AX_X;
      max_len_r    <= '0;
      have_held_r  <= 1'b0;
      discarding_r <= 1'b0;
      walk_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      plan_r       <= plan_nxt;
      axis_r       <= axis_nxt;
      max_len_r    <= max_len_nxt;
      have_held_r  <= have_held_nxt;
      discarding_r <= discarding_nxt;
      walk_r       <= walk_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_x_r   <= held_x_nxt;
    held_y_r   <= held_y_nxt;
    held_z_r   <= held_z_nxt;
    pt_r       <= pt_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    rad_r      <= rad_nxt;
    srem_r     <= srem_nxt;
    leg_r      <= leg_nxt;
    rem_r      <= rem_nxt;
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    lm_r       <= lm_nxt;
    lhi_r      <= lhi_nxt;
    llo_r      <= llo_nxt;
    num_r      <= num_nxt;
    drem_r     <= drem_nxt;
    quo_r      <= quo_nxt;
    cut_x_r    <= cut_x_nxt;
    cut_y_r    <= cut_y_nxt;
    cut_z_r    <= cut_z_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_hold_xor_discard: assert property (@(posedge clk) disable iff (!rst_n)
    !(have_held_r && discarding_r))
    else $error("held point present while discarding");

  a_walk_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_r != '0) |-> have_held_r)
    else $error("walked length nonzero without a held point");

  a_clip_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.was_clipped) |-> out_data_r.out_last)
    else $error("clipped result not marked last");

  a_idle_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && have_held_r && !discarding_r) |=> (state_r == plc_pkg::S_DIFF))
    else $error("leg computation did not start");
`endif

endmodule
`default_nettype wire

>>> verif/polyline_length_clip_tb.sv
// Self-checking testbench for polyline_length_clip: routes of random points, cap settings.
// Depends on plc_pkg and rtl/polyline_length_clip.sv; predicts each emitted point.
module polyline_length_clip_tb;

  localparam int CW = plc_pkg::COORD_BITS;
  localparam int LW = plc_pkg::LEN_BITS;
  localparam int WB = plc_pkg::WALK_BITS;
  localparam int SW = 2 * CW + 3;

  localparam int WALK_LIMIT = 20000;
  localparam logic [WB-1:0] WALK_SAT = '1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  plc_pkg::in_pt_t in_data;
  logic out_valid;
  logic out_ready;
  plc_pkg::out_pt_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [LW-1:0] cfg_data;

  polyline_length_clip DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the clipper state.
  logic [LW-1:0] cap;
  logic signed [CW-1:0] hx, hy, hz;
  logic have_pt;
  logic [WB-1:0] walked;
  logic dropping;

  plc_pkg::out_pt_t pending_pts[$];
  int errors;
  int idle_cycles;
  int send_gap_pct;
  int recv_stall_pct;
  bit recv_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] leg_len(input logic signed [CW-1:0] ax, ay, bx, by);
    logic signed [CW:0] dx, dy;
    logic [SW-1:0] sq, c, r;
    dx = {bx[CW-1], bx} - {ax[CW-1], ax};
    dy = {by[CW-1], by} - {ay[CW-1], ay};
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = SW'($unsigned(dx)) * SW'($unsigned(dx)) + SW'($unsigned(dy)) * SW'($unsigned(dy));
    r = '0;
    // The root stays below 2^33, so every trial square fits the sum width.
    for (int b = CW; b >= 0; b--) begin
      c = r | (SW'(1) << b);
      if (c * c <= sq) r = c;
    end
    return r[63:0];
  endfunction

  function automatic logic signed [CW-1:0] cut_coord(
      input logic signed [CW-1:0] h, p, input logic [63:0] rem, leg);
    logic signed [CW+1:0] d;
    logic [127:0] q;
    d = {{2{p[CW-1]}}, p} - {{2{h[CW-1]}}, h};
    q = ((d < 0) ? 128'($unsigned(-d)) : 128'($unsigned(d))) * 128'(rem) / 128'(leg);
    return (d < 0) ? CW'(h - q) : CW'(h + q);
  endfunction

  function automatic plc_pkg::out_pt_t mk(input logic signed [CW-1:0] x, y, z,
                                          input logic last, clip);
    plc_pkg::out_pt_t o;
    o.out_x = x; o.out_y = y; o.out_z = z; o.out_last = last; o.was_clipped = clip;
    return o;
  endfunction

  function automatic void add_pending(input plc_pkg::out_pt_t o);
    pending_pts = {pending_pts, o};
  endfunction

  task automatic predict_point(input plc_pkg::in_pt_t p);
    logic [63:0] leg, rem;
    if (dropping) begin
      if (p.route_end) begin have_pt = 1'b0; walked = '0; dropping = 1'b0; end
      return;
    end
    if (!have_pt) begin
      if (p.route_end) add_pending(mk(p.pt_x, p.pt_y, p.pt_z, 1'b1, 1'b0));
      else begin hx = p.pt_x; hy = p.pt_y; hz = p.pt_z; have_pt = 1'b1; end
      return;
    end
    leg = leg_len(hx, hy, p.pt_x, p.pt_y);
    if (cap == '0 || 64'(walked) + leg <= 64'(cap)) begin
      add_pending(mk(hx, hy, hz, 1'b0, 1'b0));
      walked = (64'(walked) + leg > 64'(WALK_SAT)) ? WALK_SAT : WB'(64'(walked) + leg);
      if (p.route_end) begin
        add_pending(mk(p.pt_x, p.pt_y, p.pt_z, 1'b1, 1'b0));
        have_pt = 1'b0; walked = '0;
      end else begin
        hx = p.pt_x; hy = p.pt_y; hz = p.pt_z;
      end
      return;
    end
    if (64'(walked) >= 64'(cap) || 64'(cap) - 64'(walked) < 64'(plc_pkg::CUT_MIN)) begin
      add_pending(mk(hx, hy, hz, 1'b1, 1'b1));
    end else begin
      rem = 64'(cap) - 64'(walked);
      add_pending(mk(hx, hy, hz, 1'b0, 1'b0));
      add_pending(mk(cut_coord(hx, p.pt_x, rem, leg), cut_coord(hy, p.pt_y, rem, leg),
                     cut_coord(hz, p.pt_z, rem, leg), 1'b1, 1'b1));
    end
    have_pt = 1'b0; walked = '0;
    dropping = !p.route_end;
  endtask

  // Valid stays high after a transaction when the next point follows at once.
  task automatic send_point(input logic signed [CW-1:0] x, y, z, input logic last);
    plc_pkg::in_pt_t p;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    p.pt_x = x; p.pt_y = y; p.pt_z = z; p.route_end = last;
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(p);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cap(input logic [LW-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(3))
      0: return $signed($urandom());
      1: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  task automatic send_route(input int pts);
    for (int i = 0; i < pts; i++)
      send_point(rnd_coord(), rnd_coord(), rnd_coord(), i == pts - 1);
  endtask

  // Receiver: random stalls, plus a long forced hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected output point %h", out_data);
        errors++;
      end else begin
        plc_pkg::out_pt_t e;
        e = pending_pts.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $error("out_x exp %0d got %0d", e.out_x, out_data.out_x); errors++; end
        if (out_data.out_y !== e.out_y) begin
          $error("out_y exp %0d got %0d", e.out_y, out_data.out_y); errors++; end
        if (out_data.out_z !== e.out_z) begin
          $error("out_z exp %0d got %0d", e.out_z, out_data.out_z); errors++; end
        if (out_data.out_last !== e.out_last) begin
          $error("out_last exp %0b got %0b", e.out_last, out_data.out_last); errors++; end
        if (out_data.was_clipped !== e.was_clipped) begin
          $error("was_clipped exp %0b got %0b", e.was_clipped, out_data.was_clipped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WALK_LIMIT) begin
      $display("FAIL polyline_length_clip");
      $finish;
    end
  end

  task automatic test_directed();
    write_cap('0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 0, 1'b1);
    write_cap(31'h0005_0000);
    // The cap is used up exactly at a corner, then dropped points until the route end.
    send_point(0, 0, 0, 1'b0);
    send_point(32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000, 1'b0);
    send_point(-32'sh0003_0000, 32'sh0004_0000, -32'sh0001_0000, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(0, 0, 0, 1'b1);
    // Less than a hundredth of a yard left: the route ends at the corner.
    send_point(0, 0, 0, 1'b0);
    send_point(32'sh0004_ffff, 0, 5, 1'b0);
    send_point(32'sh0009_0000, 0, 7, 1'b1);
    // Exactly the cap, then a cut toward negative coordinates.
    send_point(0, 0, 0, 1'b0);
    send_point(32'sh0005_0000, 0, 0, 1'b0);
    send_point(32'sh0005_0000, 0, 0, 1'b1);
    send_point(0, 0, 9, 1'b0);
    send_point(-32'sh0008_0000, -32'sh0001_0000, -32'sh0040_0000, 1'b1);
    write_cap(31'h7fff_ffff);
    send_point(32'sh8000_0000, 32'sh8000_0000, 0, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1, 1'b0);
    send_point(32'sh8000_0000, 0, 2, 1'b1);
    write_cap(31'd1);
    send_point(0, 0, 0, 1'b0);
    send_point(1, 0, 0, 1'b1);
  endtask

  task automatic test_random(input int gap, input int stall, input int items);
    int sent;
    send_gap_pct = gap;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      int n;
      int kind;
      kind = $urandom_range(9);
      if (kind == 0) write_cap('0);
      else if (kind == 1) write_cap(LW'($urandom()));
      else if (kind == 2) write_cap(LW'($urandom_range(32'h0100_0000)));
      n = $urandom_range(1, 8);
      send_route(n);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_cap('0);
    recv_hold = 1;
    fork
      begin repeat (3000) @(posedge clk); recv_hold = 0; end
      send_route(12);
    join
    wait_drained();
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    recv_hold = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cap = '0; hx = '0; hy = '0; hz = '0; have_pt = 1'b0; walked = '0; dropping = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(10, 72, 200);
    test_random(72, 10, 200);
    test_random(0, 0, 200);
    wait_drained();
    if (errors == 0) $display("PASS polyline_length_clip");
    else $display("FAIL polyline_length_clip");
    $finish;
  end
endmodule
